[hdl/lsg_pkg.sv]
// Shared types and constants for the scanline timing generator.
// No dependencies; used by lcd_scanline_timing_generator_unit.
`default_nettype none

package lsg_pkg;

  // Line timing
  localparam int unsigned DRAW_CYCLES   = 960;
  localparam int unsigned HBLANK_CYCLES = 272;
  localparam int unsigned VISIBLE_LINES = 160;
  localparam int unsigned TOTAL_LINES   = 228;

  // Field widths
  localparam int unsigned ELAPSED_W = 12;
  localparam int unsigned LINE_W    = 8;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  // Event counter floor
  localparam logic signed [COUNT_W-1:0] COUNTER_MIN = -13'sd4095;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_COMPARE = 4'd0,
    REG_HBLANK_IRQ   = 4'd1,
    REG_VBLANK_IRQ   = 4'd2,
    REG_MATCH_IRQ    = 4'd3
  } reg_index_t;

  // One result, packed lowest field last so it maps to tdata from bit 0
  typedef struct packed {
    logic signed [COUNT_W-1:0] cycles_to_event;
    logic                      frame_done;
    logic                      vblank_start;
    logic                      visible_hblank_start;
    logic                      irq_match;
    logic                      vblank_irq;
    logic                      hblank_irq;
    logic                      line_match;
    logic                      in_vblank;
    logic                      in_hblank;
    logic [LINE_W-1:0]         line_number;
  } result_t;

endpackage

`default_nettype wire

[hdl/lcd_scanline_timing_generator_unit.sv]
// Scanline timing generator: event counter, line counter and blank flags.
// Depends on lsg_pkg.
//
//  channel | dir | handshake                  | payload
//  s_axis  | in  | s_axis_tvalid/tready       | tdata[11:0] elapsed_cycles
//  m_axis  | out | m_axis_tvalid/tready       | tdata[29:0] result fields
//  cfg     | in  | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// One item per clock while the output is not stalled: the timing state and the
// result register are both loaded on the clock edge that accepts the item.
// The input is taken whenever the output register is empty or being drained.
// cfg_ready is always high; writes take effect on the next clock.
// rst (synchronous) restores counter 960, line 0, all flags and config registers 0.
`default_nettype none

module lcd_scanline_timing_generator_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // [11:0] elapsed_cycles, [15:12] zero
  input  wire logic [lsg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [7:0] line_number, [8] in_hblank, [9] in_vblank, [10] line_match,
  // [11] hblank_irq, [12] vblank_irq, [13] irq_match,
  // [14] visible_hblank_start, [15] vblank_start, [16] frame_done,
  // [29:17] cycles_to_event, [31:30] zero
  output logic [lsg_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned CW = lsg_pkg::COUNT_W;
  localparam int unsigned LW = lsg_pkg::LINE_W;

  // Configuration registers
  logic [LW-1:0] line_compare;
  logic          hblank_irq_enable;
  logic          vblank_irq_enable;
  logic          match_irq_enable;

  // Timing state
  logic signed [CW-1:0] event_counter, event_counter_next;
  logic [LW-1:0]        line_counter, line_counter_next;
  logic                 hblank_flag, hblank_flag_next;
  logic                 vblank_flag, vblank_flag_next;
  logic                 match_flag, match_flag_next;

  // Output register
  lsg_pkg::result_t result, result_next;
  logic             out_valid;

  logic                      in_accept;
  logic [lsg_pkg::ELAPSED_W-1:0] elapsed;
  logic signed [CW:0]        diff;
  logic signed [CW:0]        sat;
  logic [LW-1:0]             line_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign elapsed       = s_axis_tdata[lsg_pkg::ELAPSED_W-1:0];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_compare      <= '0;
      hblank_irq_enable <= 1'b0;
      vblank_irq_enable <= 1'b0;
      match_irq_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsg_pkg::REG_LINE_COMPARE: line_compare      <= cfg_data[LW-1:0];
        lsg_pkg::REG_HBLANK_IRQ:   hblank_irq_enable <= cfg_data[0];
        lsg_pkg::REG_VBLANK_IRQ:   vblank_irq_enable <= cfg_data[0];
        lsg_pkg::REG_MATCH_IRQ:    match_irq_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Subtract, floor at COUNTER_MIN, then at most one transition
  always_comb begin
    diff = {event_counter[CW-1], event_counter}
         - $signed({{(CW+1-lsg_pkg::ELAPSED_W){1'b0}}, elapsed});
    if (diff < $signed({lsg_pkg::COUNTER_MIN[CW-1], lsg_pkg::COUNTER_MIN}))
      sat = {lsg_pkg::COUNTER_MIN[CW-1], lsg_pkg::COUNTER_MIN};
    else
      sat = diff;
    line_inc = line_counter + LW'(1);

    event_counter_next = sat[CW-1:0];
    line_counter_next  = line_counter;
    hblank_flag_next   = hblank_flag;
    vblank_flag_next   = vblank_flag;
    match_flag_next    = match_flag;
    result_next        = '0;

    if (sat <= 0) begin
      if (!hblank_flag) begin
        // draw -> horizontal blank
        event_counter_next = sat[CW-1:0] + CW'(lsg_pkg::HBLANK_CYCLES);
        hblank_flag_next   = 1'b1;
        result_next.visible_hblank_start = !vblank_flag;
        result_next.hblank_irq           = hblank_irq_enable;
      end else begin
        // horizontal blank -> next line
        event_counter_next = sat[CW-1:0] + CW'(lsg_pkg::DRAW_CYCLES);
        hblank_flag_next   = 1'b0;
        line_counter_next  = line_inc;
        if (line_inc == LW'(lsg_pkg::VISIBLE_LINES)) begin
          vblank_flag_next         = 1'b1;
          result_next.vblank_start = 1'b1;
          result_next.vblank_irq   = vblank_irq_enable;
        end else if (line_inc == LW'(lsg_pkg::TOTAL_LINES)) begin
          vblank_flag_next       = 1'b0;
          line_counter_next      = '0;
          result_next.frame_done = 1'b1;
        end
        match_flag_next       = (line_counter_next == line_compare);
        result_next.irq_match = match_flag_next && match_irq_enable;
      end
    end

    result_next.line_number     = line_counter_next;
    result_next.in_hblank       = hblank_flag_next;
    result_next.in_vblank       = vblank_flag_next;
    result_next.line_match      = match_flag_next;
    result_next.cycles_to_event = event_counter_next;
  end

  // Timing state update per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      event_counter <= CW'(lsg_pkg::DRAW_CYCLES);
      line_counter  <= '0;
      hblank_flag   <= 1'b0;
      vblank_flag   <= 1'b0;
      match_flag    <= 1'b0;
    end else if (in_accept) begin
      event_counter <= event_counter_next;
      line_counter  <= line_counter_next;
      hblank_flag   <= hblank_flag_next;
      vblank_flag   <= vblank_flag_next;
      match_flag    <= match_flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(lsg_pkg::OUT_TDATA_W - $bits(lsg_pkg::result_t)){1'b0}}, result};

  // Checks
  a_counter_floor: assert property (@(posedge clk) disable iff (rst)
    event_counter >= lsg_pkg::COUNTER_MIN)
    else $error("event counter below floor");

  a_frame_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.frame_done |-> result.line_number == '0 && !result.in_vblank)
    else $error("frame done without wrap to line 0");

  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.vblank_start |->
      result.in_vblank && result.line_number == LW'(lsg_pkg::VISIBLE_LINES))
    else $error("vblank start off the first blank line");

  a_vblank_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.vblank_irq |-> result.vblank_start)
    else $error("vblank irq without vblank entry");

  a_state_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> line_counter == result.line_number && hblank_flag == result.in_hblank)
    else $error("state and result disagree");

endmodule

`default_nettype wire

[verif/lsg_result_checker.sv]
// Result checker for the scanline timing generator: predicts each result from
// the accepted elapsed-cycle transactions and register writes, then compares.
// Depends on lsg_pkg; instantiated beside the DUT by the testbench top.
`timescale 1ns / 100ps

module lsg_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [lsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                             mismatch_count,
  output int                             results_outstanding,
  output logic [lsg_pkg::LINE_W-1:0]      line_now
);

  // Predicted timing state
  int                         event_count;
  logic [lsg_pkg::LINE_W-1:0] line_cnt;
  logic                       hblank_on;
  logic                       vblank_on;
  logic                       match_on;

  // Predicted register file
  logic [lsg_pkg::LINE_W-1:0] compare_line;
  logic                       hblank_irq_on;
  logic                       vblank_irq_on;
  logic                       match_irq_on;

  lsg_pkg::result_t timing_results[$];
  int               fail_total = 0;
  int               queued     = 0;

  assign mismatch_count      = fail_total;
  assign results_outstanding = queued;
  assign line_now            = line_cnt;

  // Advance the display timing by one elapsed-cycle transaction
  task automatic step_timing(input logic [lsg_pkg::ELAPSED_W-1:0] elapsed,
                             output lsg_pkg::result_t res);
    res = '0;
    event_count = event_count - int'(elapsed);
    if (event_count < int'(lsg_pkg::COUNTER_MIN)) event_count = int'(lsg_pkg::COUNTER_MIN);
    // at most one transition per transaction
    if (event_count <= 0) begin
      if (!hblank_on) begin
        event_count = event_count + int'(lsg_pkg::HBLANK_CYCLES);
        hblank_on = 1'b1;
        res.visible_hblank_start = !vblank_on;
        res.hblank_irq = hblank_irq_on;
      end else begin
        event_count = event_count + int'(lsg_pkg::DRAW_CYCLES);
        hblank_on = 1'b0;
        line_cnt = line_cnt + 1'b1;
        // vblank entry wins over the wrap when both limits coincide
        if (line_cnt == lsg_pkg::LINE_W'(lsg_pkg::VISIBLE_LINES)) begin
          vblank_on = 1'b1;
          res.vblank_start = 1'b1;
          res.vblank_irq = vblank_irq_on;
        end else if (line_cnt == lsg_pkg::LINE_W'(lsg_pkg::TOTAL_LINES)) begin
          vblank_on = 1'b0;
          line_cnt = '0;
          res.frame_done = 1'b1;
        end
        match_on = (line_cnt == compare_line);
        res.irq_match = match_on && match_irq_on;
      end
    end
    res.line_number     = line_cnt;
    res.in_hblank       = hblank_on;
    res.in_vblank       = vblank_on;
    res.line_match      = match_on;
    res.cycles_to_event = event_count[lsg_pkg::COUNT_W-1:0];
  endtask

  function automatic int field_diff(string name, int want, int got);
    if (want == got) return 0;
    $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  function automatic int result_diff(lsg_pkg::result_t want, lsg_pkg::result_t got,
                                     logic [1:0] pad);
    int bad;
    bad = field_diff("line_number", want.line_number, got.line_number);
    bad += field_diff("in_hblank", want.in_hblank, got.in_hblank);
    bad += field_diff("in_vblank", want.in_vblank, got.in_vblank);
    bad += field_diff("line_match", want.line_match, got.line_match);
    bad += field_diff("hblank_irq", want.hblank_irq, got.hblank_irq);
    bad += field_diff("vblank_irq", want.vblank_irq, got.vblank_irq);
    bad += field_diff("irq_match", want.irq_match, got.irq_match);
    bad += field_diff("visible_hblank_start", want.visible_hblank_start,
                      got.visible_hblank_start);
    bad += field_diff("vblank_start", want.vblank_start, got.vblank_start);
    bad += field_diff("frame_done", want.frame_done, got.frame_done);
    bad += field_diff("cycles_to_event", int'(want.cycles_to_event),
                      int'(got.cycles_to_event));
    bad += field_diff("tdata padding", 0, pad);
    return bad;
  endfunction

  always @(posedge clk) begin
    lsg_pkg::result_t want;
    lsg_pkg::result_t got;
    int               bad;
    bad = 0;
    if (rst) begin
      event_count   = int'(lsg_pkg::DRAW_CYCLES);
      line_cnt      = '0;
      hblank_on     = 1'b0;
      vblank_on     = 1'b0;
      match_on      = 1'b0;
      compare_line  = '0;
      hblank_irq_on = 1'b0;
      vblank_irq_on = 1'b0;
      match_irq_on  = 1'b0;
      timing_results.delete();
    end else begin
      // output transaction: compare against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = lsg_pkg::result_t'(m_axis_tdata[$bits(lsg_pkg::result_t)-1:0]);
        if (timing_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h",
                   $time, m_axis_tdata);
          bad = 1;
        end else begin
          want = timing_results.pop_front();
          bad = result_diff(want, got, m_axis_tdata[lsg_pkg::OUT_TDATA_W-1 -: 2]);
        end
      end
      // register write; only issued while the block is idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsg_pkg::REG_LINE_COMPARE: compare_line  = cfg_data[lsg_pkg::LINE_W-1:0];
          lsg_pkg::REG_HBLANK_IRQ:   hblank_irq_on = cfg_data[0];
          lsg_pkg::REG_VBLANK_IRQ:   vblank_irq_on = cfg_data[0];
          lsg_pkg::REG_MATCH_IRQ:    match_irq_on  = cfg_data[0];
          default: ;
        endcase
      end
      // input transaction: predict its result
      if (s_axis_tvalid && s_axis_tready) begin
        step_timing(s_axis_tdata[lsg_pkg::ELAPSED_W-1:0], want);
        timing_results.push_back(want);
      end
    end
    fail_total <= fail_total + bad;
    queued     <= timing_results.size();
  end

endmodule

[verif/tb_lcd_scanline_timing_generator_unit.sv]
// Testbench top for lcd_scanline_timing_generator_unit: drives elapsed-cycle
// and register write transactions, stalls the result stream, gives the verdict.
// Depends on lsg_pkg, the DUT and lsg_result_checker.
`timescale 1ns / 100ps

module tb_lcd_scanline_timing_generator_unit;

  localparam int RESET_CYCLES   = 10;
  localparam int SEGMENTS       = 9;
  localparam int SEGMENT_ITEMS  = 92;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_ELAPSED    = (1 << lsg_pkg::ELAPSED_W) - 1;
  localparam logic [lsg_pkg::CFG_IDX_W-1:0] FIRST_UNMAPPED_INDEX = 4'd4;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [lsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lsg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [lsg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int                         mismatch_count;
  int                         results_outstanding;
  logic [lsg_pkg::LINE_W-1:0] line_now;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always #4 clk = ~clk;

  lcd_scanline_timing_generator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lsg_result_checker u_checker (.*);

  // Result stream back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One elapsed-cycle transaction, with random idle cycles ahead of it
  task automatic send_elapsed(input int elapsed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lsg_pkg::IN_TDATA_W'(elapsed);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold off input until every predicted result has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lsg_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= lsg_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full register set; spare upper bits on the enables and a write to an
  // unmapped index, both of which must be ignored
  task automatic configure(input int compare, input bit hb, input bit vb, input bit mt);
    write_reg(lsg_pkg::REG_LINE_COMPARE, compare);
    write_reg(lsg_pkg::REG_HBLANK_IRQ, ($urandom_range(127) << 1) | hb);
    write_reg(lsg_pkg::REG_VBLANK_IRQ, ($urandom_range(127) << 1) | vb);
    write_reg(lsg_pkg::REG_MATCH_IRQ, ($urandom_range(127) << 1) | mt);
    write_reg(lsg_pkg::CFG_IDX_W'($urandom_range(FIRST_UNMAPPED_INDEX,
                                                 (1 << lsg_pkg::CFG_IDX_W) - 1)),
              $urandom_range(255));
    cfg_valid <= 1'b0;
  endtask

  // Mostly items long enough to force a transition, so the run walks
  // through whole frames; the rest short, random or at the field limits
  function automatic int random_elapsed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return $urandom_range(lsg_pkg::DRAW_CYCLES, MAX_ELAPSED);
    if (pick < 85) return $urandom_range(63);
    if (pick < 95) return $urandom_range(MAX_ELAPSED);
    return $urandom_range(1) ? MAX_ELAPSED : 0;
  endfunction

  initial begin
    int directed_items[$];
    int compare;
    int waited;
    directed_items = '{0, 959, 1, 271, 1, MAX_ELAPSED, MAX_ELAPSED, 0, 0,
                       MAX_ELAPSED, MAX_ELAPSED, 12'hAAA, 12'h555, 960, 961,
                       MAX_ELAPSED, 0, 2048, 1024, 3000, 1};
    waited = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: line 1 matches, all interrupts enabled
    send_idle_pct = 35;
    recv_idle_pct = 57;
    configure(1, 1'b1, 1'b1, 1'b1);
    foreach (directed_items[i]) send_elapsed(directed_items[i]);

    // Random segments, each with its own register setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin send_idle_pct = 35; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      wait_drained();
      if (seg == 1) configure(255, 1'b0, 1'b0, 1'b0);
      else if (seg == 2) configure(0, 1'b1, 1'b1, 1'b1);
      else begin
        // compare line a little ahead of the current line so it is hit
        compare = (int'(line_now) + $urandom_range(1, 24)) % lsg_pkg::TOTAL_LINES;
        configure(compare, $urandom_range(1), $urandom_range(1), $urandom_range(1));
      end
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        if (seg == 4 && i == SEGMENT_ITEMS / 2) wait_drained();
        send_elapsed(random_elapsed());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for the output register latency
    while (results_outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (results_outstanding != 0)
      $display("%0t ns: %0d results never arrived", $time, results_outstanding);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("%0t ns: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
